### rtl/lfrc_pkg.sv
package lfrc_pkg;

  // Framing constants
  localparam int LENGTH_WORD_BYTES = 4;
  localparam int INDEX_ENTRY_BYTES = 20;

  localparam logic [1:0]  WORD_LAST  = 2'(LENGTH_WORD_BYTES - 1);
  localparam logic [7:0]  ENTRY_LAST = 8'(INDEX_ENTRY_BYTES - 1);
  localparam logic [31:0] MIN_LENGTH = 32'(2 * LENGTH_WORD_BYTES);

  // File kinds
  localparam logic [1:0] KIND_INDEX    = 2'd0;
  localparam logic [1:0] KIND_METADATA = 2'd1;
  localparam logic [1:0] KIND_VOLUME   = 2'd2;

  typedef logic [2:0] status_t;

  // Check status codes
  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_NO_DATA     = 3'd1;
  localparam status_t ST_EOF_BODY    = 3'd2;
  localparam status_t ST_EOF_TRAILER = 3'd3;
  localparam status_t ST_MISMATCH    = 3'd4;
  localparam status_t ST_EOF_HEADER  = 3'd5;
  localparam status_t ST_EOF_ENTRY   = 3'd6;

endpackage

### rtl/length_framed_record_checker_unit.sv
// Checks a byte stream of records, each framed by a 4-byte big-endian length
// header and a matching 4-byte trailer (the length counts both words). With
// file_kind 0 (index file) the first good record is followed by fixed-size
// index entries, and each whole entry counts as a record. Every input transfer
// is one byte or one end marker; only the end marker produces a result, which
// carries the status, the saturating record count and, on a length mismatch,
// the header and trailer words. The block takes one item per cycle unless
// in_stall is high: an accepted item is registered in the input register, then
// its byte updates the framing counters, and an end marker registers the result.
// A result held by out_stall blocks input only when a second end marker waits
// in the input register. Framing state is reset after each end marker;
// the user must write file_kind only while the block is idle (not enforced).
module length_framed_record_checker_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_stream,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lfrc_pkg::status_t    check_status,
  output logic [31:0]          record_count,
  output logic [31:0]          header_word,
  output logic [31:0]          trailer_word
);
  import lfrc_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_BODY    = 3'd1;
  localparam logic [2:0] PH_TRAILER = 3'd2;
  localparam logic [2:0] PH_INDEX   = 3'd3;
  localparam logic [2:0] PH_DEAD    = 3'd4;

  logic [1:0]  file_kind;

  // input register
  logic        in_reg_valid;
  logic [7:0]  in_reg_byte;
  logic        in_reg_eos;

  // framing state
  logic [2:0]  phase, phase_next;
  logic [1:0]  word_byte_count, word_byte_count_next;
  logic [31:0] header_length, header_length_next;
  logic [31:0] body_remaining, body_remaining_next;
  logic [31:0] trailer_length, trailer_length_next;
  logic [31:0] records_seen, records_seen_next;
  logic [7:0]  entry_byte_count, entry_byte_count_next;
  status_t     fatal_code, fatal_code_next;

  logic        process;
  logic        finish;
  logic        in_take;
  logic [31:0] header_shift;
  logic [31:0] trailer_shift;
  logic [31:0] records_inc;
  status_t     status;

  // Hold an end marker while the previous result still waits
  assign process  = in_reg_valid && (!in_reg_eos || !out_valid || !out_stall);
  assign finish   = process && in_reg_eos;
  assign in_stall = in_reg_valid && !process;
  assign in_take  = in_valid && !in_stall;

  assign header_shift  = {header_length[23:0], in_reg_byte};
  assign trailer_shift = {trailer_length[23:0], in_reg_byte};
  assign records_inc   = (records_seen == 32'hFFFF_FFFF) ? records_seen
                                                          : records_seen + 32'd1;

  // Write the file kind register
  always_ff @(posedge clk) begin
    if (rst) begin
      file_kind <= KIND_VOLUME;
    end else if (cfg_we) begin
      file_kind <= cfg_data;
    end
  end

  // Capture an accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (process) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg_byte <= data_byte;
      in_reg_eos  <= end_of_stream;
    end
  end

  // Pick the end-of-stream status
  always_comb begin
    if (fatal_code != ST_OK) begin
      status = fatal_code;
    end else if (phase == PH_BODY) begin
      status = ST_EOF_BODY;
    end else if (phase == PH_TRAILER) begin
      status = ST_EOF_TRAILER;
    end else if (phase == PH_HEADER && word_byte_count != 2'd0) begin
      status = ST_EOF_HEADER;
    end else if (phase == PH_INDEX && entry_byte_count != 8'd0) begin
      status = ST_EOF_ENTRY;
    end else if (records_seen < 32'd2) begin
      status = ST_NO_DATA;
    end else begin
      status = ST_OK;
    end
  end

  // Advance the framing state by one byte, or clear it on an end marker
  always_comb begin
    phase_next            = phase;
    word_byte_count_next  = word_byte_count;
    header_length_next    = header_length;
    body_remaining_next   = body_remaining;
    trailer_length_next   = trailer_length;
    records_seen_next     = records_seen;
    entry_byte_count_next = entry_byte_count;
    fatal_code_next       = fatal_code;

    if (finish) begin
      phase_next            = PH_HEADER;
      word_byte_count_next  = 2'd0;
      header_length_next    = 32'd0;
      body_remaining_next   = 32'd0;
      trailer_length_next   = 32'd0;
      records_seen_next     = 32'd0;
      entry_byte_count_next = 8'd0;
      fatal_code_next       = ST_OK;
    end else if (process) begin
      unique case (phase)
        PH_HEADER: begin
          header_length_next   = header_shift;
          word_byte_count_next = word_byte_count + 2'd1;
          if (word_byte_count == WORD_LAST) begin
            word_byte_count_next = 2'd0;
            if (!header_shift[31] && header_shift > MIN_LENGTH) begin
              body_remaining_next = header_shift - MIN_LENGTH;
              phase_next          = PH_BODY;
            end else begin
              body_remaining_next = 32'd0;
              phase_next          = PH_TRAILER;
            end
          end
        end
        PH_BODY: begin
          body_remaining_next = body_remaining - 32'd1;
          if (body_remaining == 32'd1) begin
            phase_next = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          trailer_length_next  = trailer_shift;
          word_byte_count_next = word_byte_count + 2'd1;
          if (word_byte_count == WORD_LAST) begin
            word_byte_count_next = 2'd0;
            if (trailer_shift != header_length) begin
              fatal_code_next = ST_MISMATCH;
              phase_next      = PH_DEAD;
            end else begin
              records_seen_next = records_inc;
              phase_next        = (file_kind == KIND_INDEX) ? PH_INDEX : PH_HEADER;
            end
          end
        end
        PH_INDEX: begin
          entry_byte_count_next = entry_byte_count + 8'd1;
          if (entry_byte_count == ENTRY_LAST) begin
            entry_byte_count_next = 8'd0;
            records_seen_next     = records_inc;
          end
        end
        default: begin
          // drop bytes after a fatal error
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      word_byte_count  <= 2'd0;
      header_length    <= 32'd0;
      body_remaining   <= 32'd0;
      trailer_length   <= 32'd0;
      records_seen     <= 32'd0;
      entry_byte_count <= 8'd0;
      fatal_code       <= ST_OK;
    end else begin
      phase            <= phase_next;
      word_byte_count  <= word_byte_count_next;
      header_length    <= header_length_next;
      body_remaining   <= body_remaining_next;
      trailer_length   <= trailer_length_next;
      records_seen     <= records_seen_next;
      entry_byte_count <= entry_byte_count_next;
      fatal_code       <= fatal_code_next;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      check_status <= status;
      record_count <= records_seen;
      header_word  <= (status == ST_MISMATCH) ? header_length : 32'd0;
      trailer_word <= (status == ST_MISMATCH) ? trailer_length : 32'd0;
    end
  end

  // A fatal code parks the framer until the end marker
  a_fatal_dead: assert property (@(posedge clk) disable iff (rst)
    (fatal_code != ST_OK) |-> (phase == PH_DEAD))
    else $error("fatal code set outside dead phase");

  // The body phase always has bytes left
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_remaining != 32'd0))
    else $error("body phase with no bytes remaining");

  // An end marker yields a result and a cleared stream
  a_finish_clear: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && phase == PH_HEADER && records_seen == 32'd0
                && word_byte_count == 2'd0))
    else $error("end marker did not produce a result and clear state");

  // Length words show only on a mismatch
  a_words_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && check_status != ST_MISMATCH)
      |-> (header_word == 32'd0 && trailer_word == 32'd0))
    else $error("length words nonzero without mismatch");

  // Input stalls only behind a waiting end marker
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && in_reg_eos && out_valid && out_stall))
    else $error("input stalled without a waiting result");

endmodule
